@@ src/bsc_pkg.sv @@
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int WINDOW_BYTES_DEF = 36;
	localparam int MARK_SPAN = 36;
	localparam int MARK_COUNT = 5;
	localparam int MARK_MAX = 18;
	localparam int FLAG_W = 4;
	localparam int DATA_W = 8;

	localparam logic [1:0] FLAG_CFG = 2'd0;
	localparam logic [1:0] FLAG_LOG = 2'd1;
	localparam logic [1:0] FLAG_IMPL = 2'd2;
	localparam logic [1:0] FLAG_GAME = 2'd3;

	localparam logic CLASS_NONE = 1'b0;
	localparam logic CLASS_FAMILY = 1'b1;

	localparam logic [4:0] MARK_LEN [MARK_COUNT] = '{5'd11, 5'd11, 5'd10, 5'd18, 5'd13};

	localparam logic [1:0] MARK_FLAG [MARK_COUNT] = '{FLAG_CFG, FLAG_LOG, FLAG_IMPL,
		FLAG_GAME, FLAG_GAME};

	localparam logic [DATA_W-1:0] MARK_TEXT [MARK_COUNT][MARK_MAX] = '{
		'{8'h46, 8'h46, 8'h31, 8'h33, 8'h46, 8'h69, 8'h78, 8'h2E, 8'h69, 8'h6E, 8'h69,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h46, 8'h46, 8'h31, 8'h33, 8'h46, 8'h69, 8'h78, 8'h2E, 8'h6C, 8'h6F, 8'h67,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4F, 8'h6E, 8'h65, 8'h54, 8'h77, 8'h65, 8'h61, 8'h6B, 8'h4E, 8'h47,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h46, 8'h69, 8'h6E, 8'h61, 8'h6C, 8'h20, 8'h46, 8'h61, 8'h6E, 8'h74, 8'h61,
			8'h73, 8'h79, 8'h20, 8'h58, 8'h49, 8'h49, 8'h49},
		'{8'h66, 8'h66, 8'h78, 8'h69, 8'h69, 8'h69, 8'h69, 8'h6D, 8'h67, 8'h2E, 8'h65,
			8'h78, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	function automatic logic verdict(input logic [FLAG_W-1:0] f);
		logic cfg;
		logic lg;
		logic impl;
		logic game;
		cfg = f[FLAG_CFG];
		lg = f[FLAG_LOG];
		impl = f[FLAG_IMPL];
		game = f[FLAG_GAME];
		return ((cfg && (lg || impl || game)) || (impl && lg && game)) ? CLASS_FAMILY
			: CLASS_NONE;
	endfunction

endpackage

@@ src/binary_signature_classifier.sv @@
`timescale 1ns / 1ps
// Scans a binary image streamed one byte per item and reports, on the item
// marked tlast, whether known markers of the fix family were found. One byte
// is taken every cycle: all marker comparisons, plain and UTF-16LE, run in
// parallel, combinationally, between the input register and the result register.
// The verdict is registered when its last byte is compared. Input stalls
// only when a last byte reaches the compare stage while the previous verdict
// is still waiting to be taken. m_axis_tdata holds product_class in bit 0
// and marker_flags in bits 4:1 (config, log, implementation, game).
module binary_signature_classifier import bsc_pkg::*; #(
	parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] product_class, [4:1] marker_flags, [7:5] zero
);

	localparam int HIST = WINDOW_BYTES - 1;
	localparam int HIST_OFS = WINDOW_BYTES - MARK_SPAN;

	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              last_s1;

	logic [DATA_W-1:0] hist_q [HIST];
	logic [FLAG_W-1:0] flags_q;

	logic              out_valid_q;
	logic              out_class_q;
	logic [FLAG_W-1:0] out_flags_q;

	logic [DATA_W-1:0] win [MARK_SPAN];
	logic [FLAG_W-1:0] hits;
	logic [FLAG_W-1:0] flags_next;
	logic              step_ok;
	logic              step;

	assign step_ok = !last_s1 || !out_valid_q || m_axis_tready;
	assign step = valid_s1 && step_ok;
	assign s_axis_tready = !valid_s1 || step_ok;

	always_comb begin
		for (int j = 0; j < MARK_SPAN - 1; j++)
			win[j] = hist_q[HIST_OFS + j];
		win[MARK_SPAN-1] = data_s1;
	end

	bsc_match u_match (
		.win  (win),
		.hits (hits)
	);

	assign flags_next = flags_q | hits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST; i++)
				hist_q[i] <= '0;
			flags_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				for (int i = 0; i < HIST; i++)
					hist_q[i] <= '0;
				flags_q <= '0;
			end else begin
				for (int i = 0; i < HIST - 1; i++)
					hist_q[i] <= hist_q[i+1];
				hist_q[HIST-1] <= data_s1;
				flags_q <= flags_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_class_q <= verdict(flags_next);
			out_flags_q <= flags_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, out_flags_q, out_class_q};

	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("verdict without a last byte");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (flags_q == '0 && hist_q[HIST-1] == '0))
		else $error("window or flags not cleared after last byte");

	a_family_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> ($countones(m_axis_tdata[4:1]) >= 2))
		else $error("family verdict without corroboration");

endmodule

@@ src/bsc_match.sv @@
`timescale 1ns / 1ps
module bsc_match import bsc_pkg::*; (
	input  logic [DATA_W-1:0] win [MARK_SPAN],
	output logic [FLAG_W-1:0] hits
);

	logic plain_ok [MARK_COUNT];
	logic wide_ok [MARK_COUNT];

	always_comb begin
		for (int k = 0; k < MARK_COUNT; k++) begin
			plain_ok[k] = 1'b1;
			wide_ok[k] = 1'b1;
			for (int i = 0; i < MARK_MAX; i++) begin
				if (i < int'(MARK_LEN[k])) begin
					if (win[MARK_SPAN - int'(MARK_LEN[k]) + i] != MARK_TEXT[k][i])
						plain_ok[k] = 1'b0;
					if (win[MARK_SPAN - 2 * int'(MARK_LEN[k]) + 2 * i] != MARK_TEXT[k][i])
						wide_ok[k] = 1'b0;
					if (win[MARK_SPAN - 2 * int'(MARK_LEN[k]) + 2 * i + 1] != '0)
						wide_ok[k] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hits = '0;
		for (int k = 0; k < MARK_COUNT; k++) begin
			if (plain_ok[k] || wide_ok[k])
				hits[MARK_FLAG[k]] = 1'b1;
		end
	end

endmodule
